>>> rtl/capacitated_route_list_assert.svh
// assertion macros for the route list block
`ifndef CAPACITATED_ROUTE_LIST_ASSERT_SVH
`define CAPACITATED_ROUTE_LIST_ASSERT_SVH
`ifndef SYNTH
`define CRL_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CRL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CRL_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define CRL_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/crl_pkg.sv
// ---------------------------------------------------------------------------
// crl_pkg
// shared types and constants of the route list block
// ---------------------------------------------------------------------------
package crl_pkg;
  localparam int MaxNodesDef = 64;
  localparam int MaxRouteDef = 64;
  localparam int DistBitsDef = 24;
  localparam int NodeW = 6;
  localparam int CostW = 31;
  localparam int DemW  = 16;

  localparam logic [1:0] ActLoadDist = 2'd0;
  localparam logic [1:0] ActLoadDem  = 2'd1;
  localparam logic [1:0] ActAdd      = 2'd2;
  localparam logic [1:0] ActRemove   = 2'd3;

  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StOverCap  = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  localparam logic CfgCapacity = 1'b0;
  localparam logic CfgDepot    = 1'b1;

  // control handed from the sequencer to the cell chain
  typedef struct packed {
    logic       shift;   // rotate the chain by one cell
    logic       append;  // write the new node into the tail cell
    logic       drop;    // while rotating, leave out the matching cell once
  } chain_ctl_t;
endpackage

>>> rtl/capacitated_route_list.sv
// ---------------------------------------------------------------------------
// capacitated_route_list
// one vehicle route with demand table and distance memory
// ---------------------------------------------------------------------------
// One request is handled at a time. A load goes from its acceptance through
// S_DEM to S_OUT. An add or remove rotates the whole route ring once (its
// length taken after an add, before a remove) through a chain of cells, one
// cell per cycle, and reads one leg from the distance memory each cycle. A
// remove finds and deletes the first match during the same pass. The single
// port of the distance memory is why the legs are read one at a time.
// Results sit in an output register, and the next request is taken once the
// result is taken.
// The demand table reads as zero after reset through per-entry written flags.
module capacitated_route_list #(
  parameter int MaxNodes = crl_pkg::MaxNodesDef,
  parameter int MaxRoute = crl_pkg::MaxRouteDef,
  parameter int DistBits = crl_pkg::DistBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [5:0]  node_i,
  input  logic [5:0]  column_node_i,
  input  logic [23:0] load_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] total_demand_o,
  output logic [6:0]  client_count_o,
  output logic [30:0] route_cost_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import crl_pkg::*;
  `include "capacitated_route_list_assert.svh"

  localparam int NIdxW  = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int DAddrW = $clog2(MaxNodes * MaxNodes);
  localparam int CountW = $clog2(MaxRoute + 1);
  localparam int SumW   = (DistBits + CountW > CostW) ? DistBits + CountW : CostW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_DEM, S_WALK, S_LAST, S_WAIT, S_ACC, S_OUT
  } state_e;

  state_e            state_q;
  logic [15:0]       cap_q;
  logic [NodeW-1:0]  depot_q;
  logic [1:0]        act_q, status_q;
  logic [NodeW-1:0]  node_q, prev_q;
  logic [NodeW-1:0]  col_q;
  logic [23:0]       val_q;
  logic [CountW-1:0] count_q, cnt_walk_q, idx_q;
  logic [DemW-1:0]   dsum_q;
  logic [CostW-1:0]  cost_q;
  logic [SumW-1:0]   acc_q;
  logic              found_q, lvalid_q, lzero_q;
  logic [MaxNodes-1:0] dem_valid_q;
  logic [DemW-1:0]   dem_rd_q;

  logic [NodeW-1:0]   head_w;
  logic [DistBits-1:0] dist_rd_w;
  chain_ctl_t         ctl_w;
  logic               dist_we_w;
  logic [DAddrW-1:0]  dist_addr_w;
  logic [NodeW-1:0]   from_w, to_w;
  logic               leg_zero_w, match_w, walking_w;
  logic [SumW-1:0]    acc_add_w;
  logic               dem_we_w;
  logic [NIdxW-1:0]   dem_addr_w;
  logic [DemW-1:0]    dem_ram_w, dem_w;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (state_q == S_OUT);
  assign status_o       = status_q;
  assign total_demand_o = dsum_q;
  assign client_count_o = 7'(count_q);
  assign route_cost_o   = cost_q;

  // leg addressing during the walk; last leg returns to the depot
  assign walking_w = (state_q == S_WALK);
  assign match_w   = walking_w && (act_q == ActRemove) && !found_q &&
                     (head_w == node_q);
  assign from_w    = prev_q;
  assign to_w      = (state_q == S_LAST) ? depot_q : head_w;
  assign leg_zero_w = (32'(from_w) >= 32'(MaxNodes)) || (32'(to_w) >= 32'(MaxNodes));
  assign dist_we_w = (state_q == S_DEM) && (act_q == ActLoadDist) &&
                     (32'(node_q) < 32'(MaxNodes)) && (32'(col_q) < 32'(MaxNodes));
  assign dist_addr_w = dist_we_w ?
                       DAddrW'(32'(node_q) * 32'(MaxNodes) + 32'(col_q)) :
                       DAddrW'(32'(from_w) * 32'(MaxNodes) + 32'(to_w));

  // demand lookup: read on acceptance, written in the following cycle
  assign dem_we_w   = (state_q == S_DEM) && (act_q == ActLoadDem) &&
                      (32'(node_q) < 32'(MaxNodes));
  assign dem_addr_w = (state_q == S_IDLE) ? NIdxW'(node_i) : NIdxW'(node_q);
  assign dem_w      = ((32'(node_q) < 32'(MaxNodes)) && dem_valid_q[dem_addr_w]) ?
                      dem_ram_w : '0;

  // chain control: append in S_DEM on accepted add, rotate while walking
  always_comb begin
    ctl_w.append = (state_q == S_DEM) && (act_q == ActAdd) && (status_q == StDone);
    ctl_w.shift  = walking_w;
    ctl_w.drop   = match_w;
  end

  crl_ram #(.Width(DistBits), .Depth(MaxNodes * MaxNodes)) u_dist (
    .clk_i  (clk_i),
    .we_i   (dist_we_w),
    .addr_i (dist_addr_w),
    .wdata_i(DistBits'(val_q)),
    .rdata_o(dist_rd_w)
  );

  crl_ram #(.Width(DemW), .Depth(MaxNodes)) u_dem (
    .clk_i  (clk_i),
    .we_i   (dem_we_w),
    .addr_i (dem_addr_w),
    .wdata_i(val_q[15:0]),
    .rdata_o(dem_ram_w)
  );

  crl_chain #(.MaxRoute(MaxRoute), .CountW(CountW)) u_chain (
    .clk_i     (clk_i),
    .ctl_i     (ctl_w),
    .count_i   (ctl_w.append ? count_q : cnt_walk_q),
    .new_node_i(node_q),
    .head_o    (head_w)
  );

  assign acc_add_w = acc_q + (lzero_q ? '0 : SumW'(dist_rd_w));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= '0;
      depot_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgCapacity: cap_q   <= cfg_data_i;
        CfgDepot:    depot_q <= cfg_data_i[NodeW-1:0];
        default: ;
      endcase
    end
  end

  // written flags of the demand table, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dem_valid_q <= '0;
    end else if (dem_we_w) begin
      dem_valid_q[dem_addr_w] <= 1'b1;
    end
  end

  // sequencer with registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      dsum_q     <= '0;
      cost_q     <= '0;
      status_q   <= StDone;
      found_q    <= 1'b0;
      lvalid_q   <= 1'b0;
      act_q      <= ActLoadDist;
      node_q     <= '0;
      col_q      <= '0;
      val_q      <= '0;
      prev_q     <= '0;
      idx_q      <= '0;
      cnt_walk_q <= '0;
      acc_q      <= '0;
      lzero_q    <= 1'b0;
      dem_rd_q   <= '0;
    end else begin
      lvalid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          act_q    <= action_i;
          node_q   <= node_i;
          col_q    <= column_node_i;
          val_q    <= load_value_i;
          status_q <= StDone;
          found_q  <= 1'b0;
          state_q  <= S_DEM;
          if (action_i == ActAdd) begin
            if (32'(count_q) >= 32'(MaxRoute)) status_q <= StFull;
          end
        end
        S_DEM: begin
          prev_q <= depot_q;
          acc_q  <= '0;
          idx_q  <= '0;
          cnt_walk_q <= count_q;
          dem_rd_q <= dem_w;
          state_q <= S_OUT;
          if (act_q == ActAdd && status_q == StDone) begin
            if (17'(dsum_q) + 17'(dem_w) > 17'(cap_q)) begin
              status_q <= StOverCap;
            end else begin
              count_q    <= count_q + 1'b1;
              cnt_walk_q <= count_q + 1'b1;
              dsum_q     <= dsum_q + dem_w;
              state_q    <= S_WALK;
              idx_q      <= '0;
            end
          end else if (act_q == ActRemove) begin
            state_q <= (count_q == '0) ? S_OUT : S_WALK;
            if (count_q == '0) status_q <= StNotFound;
          end
          if (state_q == S_DEM && act_q != ActRemove &&
              !(act_q == ActAdd && status_q == StDone)) state_q <= S_OUT;
        end
        S_WALK: begin
          // one cell per cycle; legs use the surviving nodes only
          if (!match_w) begin
            prev_q   <= head_w;
            lvalid_q <= 1'b1;
            lzero_q  <= leg_zero_w;
          end else begin
            // the ring is one cell shorter from here on
            found_q    <= 1'b1;
            cnt_walk_q <= cnt_walk_q - 1'b1;
          end
          if (lvalid_q) acc_q <= acc_add_w;
          idx_q <= idx_q + 1'b1;
          if (idx_q + 1'b1 == count_q) state_q <= S_LAST;
        end
        S_LAST: begin
          if (lvalid_q) acc_q <= acc_add_w;
          lvalid_q <= 1'b1;
          lzero_q  <= leg_zero_w;
          state_q  <= S_WAIT;
        end
        S_WAIT: begin
          acc_q   <= acc_add_w;
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (act_q == ActRemove && !found_q) begin
            status_q <= StNotFound;
          end else begin
            cost_q <= (acc_q > SumW'({CostW{1'b1}})) ? {CostW{1'b1}} : acc_q[CostW-1:0];
            if (act_q == ActRemove) begin
              count_q <= count_q - 1'b1;
              dsum_q  <= (dem_rd_q > dsum_q) ? '0 : dsum_q - dem_rd_q;
            end
          end
          state_q <= S_OUT;
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `CRL_ASSERT_IMPL(a_count_max, clk_i, rst_ni, 1'b1, 32'(count_q) <= 32'(MaxRoute))
  `CRL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `CRL_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, state_q != S_IDLE, !in_ready_o)
  `CRL_ASSERT_IMPL(a_write_idle, clk_i, rst_ni, dist_we_w, state_q == S_DEM)
endmodule

>>> rtl/crl_ram.sv
// ---------------------------------------------------------------------------
// crl_ram
// generic single port ram, registered read
// ---------------------------------------------------------------------------
module crl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end
  assign rdata_o = rdata_q;
endmodule

>>> rtl/crl_cell.sv
// ---------------------------------------------------------------------------
// crl_cell
// one route entry; passes its node to the previous cell when rotating
// ---------------------------------------------------------------------------
module crl_cell #(
  parameter int NodeBits = 6
) (
  input  logic                clk_i,
  input  logic                load_i,
  input  logic [NodeBits-1:0] node_i,
  output logic [NodeBits-1:0] node_o
);
  logic [NodeBits-1:0] node_q;

  // take the neighbour's node when loaded
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      node_q <= node_i;
    end
  end
  assign node_o = node_q;
endmodule

>>> rtl/crl_chain.sv
// ---------------------------------------------------------------------------
// crl_chain
// row of route cells forming a rotating ring; cell 0 is the head
// ---------------------------------------------------------------------------
module crl_chain #(
  parameter int MaxRoute = 64,
  parameter int CountW   = 7
) (
  input  logic                    clk_i,
  input  crl_pkg::chain_ctl_t     ctl_i,
  input  logic [CountW-1:0]       count_i,
  input  logic [crl_pkg::NodeW-1:0] new_node_i,
  output logic [crl_pkg::NodeW-1:0] head_o
);
  import crl_pkg::*;

  logic [NodeW-1:0] node_w [MaxRoute];
  logic [NodeW-1:0] din_w  [MaxRoute];
  logic             ld_w   [MaxRoute];

  // ring: the head goes to the tail slot (count-1), others move one down;
  // on drop the head is discarded and the tail slot (count-1) is not written
  for (genvar g = 0; g < MaxRoute; g++) begin : g_cell
    logic is_tail;
    if (g + 1 < MaxRoute) begin : g_mid
      assign is_tail = (count_i == CountW'(g + 1));
      assign din_w[g] = ctl_i.append ? new_node_i :
                        (is_tail ? node_w[0] : node_w[g + 1]);
    end else begin : g_last
      assign is_tail = 1'b1;
      assign din_w[g] = ctl_i.append ? new_node_i : node_w[0];
    end
    assign ld_w[g] = ctl_i.append ? (count_i == CountW'(g)) :
                     (ctl_i.shift && !(ctl_i.drop && is_tail));
    crl_cell #(.NodeBits(NodeW)) u_cell (
      .clk_i (clk_i),
      .load_i(ld_w[g]),
      .node_i(din_w[g]),
      .node_o(node_w[g])
    );
  end
  assign head_o = node_w[0];
endmodule
